/* hdl/tlca_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlca_pkg
// Shared types and codes for the tree lowest-common-ancestor distance engine.
// ----------------------------------------------------------------------------
package tlca_pkg;

  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int DIST_W  = 11;
  localparam int OP_W    = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = 11'd2046;

  // Request opcodes; the fourth code is dropped without a result
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [NODE_W-1:0]  node;
    logic [NODE_W-1:0]  parent;
    logic [DEPTH_W-1:0] node_depth;
    logic [NODE_W-1:0]  other_node;
  } req_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic [DIST_W-1:0] distance;
    logic              is_build_ack;
  } rsp_t;

endpackage

`default_nettype wire

/* hdl/tlca_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlca_stream_if
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface tlca_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

/* hdl/tree_lca_distance_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tree_lca_distance_engine
// Binary-lifting lowest common ancestor and path length on a rooted tree.
//
//   port    dir  payload  role
//   req_i   in   req_t    load node / build jump table / distance query
//   rsp_o   out  rsp_t    build acknowledge or query answer
//
// One request is worked on at a time; ready is high only when the engine is
// free. The result register lets the next request in while a result waits.
// A build fills each entry with two dependent reads of the one jump port and
// a write. A query fetches both depths, then lifts the deeper node one level
// per step up to the top set bit of the depth gap, with an extra table read
// per set bit, and climbs both nodes unless the lifted node already meets the
// other. A result still waiting at the output holds the engine in its last
// state. Tables are not cleared by reset.
// ----------------------------------------------------------------------------
module tree_lca_distance_engine
  import tlca_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 11
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  tlca_stream_if.sink    req_i,
  tlca_stream_if.source  rsp_o
);

  localparam int IW       = $clog2(MAX_NODES);
  localparam int LVW      = $clog2(LEVELS);
  localparam int JT_DEPTH = LEVELS * (2 ** IW);
  localparam int JT_AW    = LVW + IW;

  localparam logic [LVW-1:0] LV_LAST = LVW'(LEVELS - 1);
  localparam logic [IW-1:0]  J_LAST  = IW'(MAX_NODES - 1);

  // Modulo by node count: reciprocal multiply, then one correction
  localparam int RED_SH = 20;
  localparam logic [30:0] RECIP = 31'((1 << RED_SH) / MAX_NODES);
  localparam logic [26:0] MOD_C = 27'(MAX_NODES);

  localparam int RI_NODE   = 0;
  localparam int RI_PARENT = 1;
  localparam int RI_OTHER  = 2;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RED1  = 5'd1;
  localparam logic [4:0] S_RED2  = 5'd2;
  localparam logic [4:0] S_BRD1  = 5'd3;
  localparam logic [4:0] S_BRD2  = 5'd4;
  localparam logic [4:0] S_BWR   = 5'd5;
  localparam logic [4:0] S_QDB   = 5'd6;
  localparam logic [4:0] S_QDW   = 5'd7;
  localparam logic [4:0] S_LIFT  = 5'd8;
  localparam logic [4:0] S_LIFTW = 5'd9;
  localparam logic [4:0] S_CHK   = 5'd10;
  localparam logic [4:0] S_CLA   = 5'd11;
  localparam logic [4:0] S_CLB   = 5'd12;
  localparam logic [4:0] S_CLC   = 5'd13;
  localparam logic [4:0] S_FIN   = 5'd14;
  localparam logic [4:0] S_FINW  = 5'd15;
  localparam logic [4:0] S_DCW   = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  // Control state
  logic [4:0] state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;

  // Payload state
  logic [OP_W-1:0]    op_q, op_d;
  logic [NODE_W-1:0]  raw_q [3];
  logic [NODE_W-1:0]  raw_d [3];
  logic [NODE_W-1:0]  quo_q [3];
  logic [NODE_W-1:0]  quo_d [3];
  logic [DEPTH_W-1:0] dep_in_q, dep_in_d;
  logic [IW-1:0]      a_q, a_d, b_q, b_d, ca_q, ca_d, anc_q, anc_d, j_q, j_d;
  logic [DEPTH_W-1:0] da_q, da_d, db_q, db_d, diff_q, diff_d;
  logic [LVW-1:0]     lv_q, lv_d;
  logic [DIST_W-1:0]  dist_q, dist_d;
  logic               ack_q, ack_d;
  rsp_t               rsp_q, rsp_d;

  // Memory ports
  logic               jt_we;
  logic [JT_AW-1:0]   jt_waddr, jt_raddr;
  logic [NODE_W-1:0]  jt_wdata, jt_rdata;
  logic               dp_we;
  logic [IW-1:0]      dp_waddr, dp_raddr;
  logic [DEPTH_W-1:0] dp_wdata, dp_rdata;

  logic [26:0]        rem [3];
  logic               out_free;
  logic               lift_end;
  logic [IW-1:0]      jt_idx;
  logic [LVW-1:0]     lv_dn;

  tlca_ram #(
    .WIDTH (NODE_W),
    .DEPTH (JT_DEPTH)
  ) u_jump_ram (
    .clk_i   (clk_i),
    .we_i    (jt_we),
    .waddr_i (jt_waddr),
    .wdata_i (jt_wdata),
    .raddr_i (jt_raddr),
    .rdata_o (jt_rdata)
  );

  tlca_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (MAX_NODES)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (dp_we),
    .waddr_i (dp_waddr),
    .wdata_i (dp_wdata),
    .raddr_i (dp_raddr),
    .rdata_o (dp_rdata)
  );

  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.data   = rsp_q;
  assign out_free     = !rsp_valid_q || rsp_o.ready;
  assign jt_idx       = IW'(jt_rdata);
  assign lv_dn        = lv_q - 1'b1;
  assign lift_end     = (lv_q == LV_LAST) || (diff_q[DEPTH_W-1:1] == '0);

  // Finish the modulo from the registered quotient estimates
  always_comb begin
    logic [26:0] prod;
    for (int i = 0; i < 3; i++) begin
      prod   = 27'(quo_q[i]) * MOD_C;
      rem[i] = 27'(raw_q[i]) - prod;
      if (rem[i] >= MOD_C) begin
        rem[i] = rem[i] - MOD_C;
      end
    end
  end

  // Sequence loads, the table build and queries
  always_comb begin
    logic [DIST_W:0] sum;
    logic [DIST_W:0] twice;
    logic [DIST_W:0] gap;
    logic [30:0]     qprod;

    state_d     = state_q;
    rsp_valid_d = rsp_valid_q;
    op_d        = op_q;
    raw_d       = raw_q;
    quo_d       = quo_q;
    dep_in_d    = dep_in_q;
    a_d         = a_q;
    b_d         = b_q;
    ca_d        = ca_q;
    anc_d       = anc_q;
    j_d         = j_q;
    da_d        = da_q;
    db_d        = db_q;
    diff_d      = diff_q;
    lv_d        = lv_q;
    dist_d      = dist_q;
    ack_d       = ack_q;
    rsp_d       = rsp_q;

    jt_we    = 1'b0;
    jt_waddr = '0;
    jt_wdata = '0;
    jt_raddr = '0;
    dp_we    = 1'b0;
    dp_waddr = '0;
    dp_wdata = '0;
    dp_raddr = '0;

    sum   = {2'b00, da_q} + {2'b00, db_q};
    twice = {1'b0, dp_rdata, 1'b0};
    gap   = sum - twice;
    qprod = '0;

    // Drop the result once taken
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d              = req_i.data.opcode;
          raw_d[RI_NODE]    = req_i.data.node;
          raw_d[RI_PARENT]  = req_i.data.parent;
          raw_d[RI_OTHER]   = req_i.data.other_node;
          dep_in_d          = req_i.data.node_depth;
          state_d           = S_RED1;
        end
      end

      S_RED1: begin
        for (int i = 0; i < 3; i++) begin
          qprod    = 31'(raw_q[i]) * RECIP;
          quo_d[i] = qprod[RED_SH +: NODE_W];
        end
        state_d = S_RED2;
      end

      S_RED2: begin
        a_d = IW'(rem[RI_NODE]);
        b_d = IW'(rem[RI_OTHER]);
        case (op_q)
          OP_LOAD: begin
            jt_we    = 1'b1;
            jt_waddr = {LVW'(0), IW'(rem[RI_NODE])};
            jt_wdata = NODE_W'(rem[RI_PARENT]);
            dp_we    = 1'b1;
            dp_waddr = IW'(rem[RI_NODE]);
            dp_wdata = dep_in_q;
            state_d  = S_IDLE;
          end
          OP_BUILD: begin
            lv_d    = LVW'(1);
            j_d     = '0;
            state_d = S_BRD1;
          end
          OP_QUERY: begin
            dp_raddr = IW'(rem[RI_NODE]);
            state_d  = S_QDB;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      // Build: entry = lower[lower[j]]
      S_BRD1: begin
        jt_raddr = {lv_dn, j_q};
        state_d  = S_BRD2;
      end

      S_BRD2: begin
        jt_raddr = {lv_dn, jt_idx};
        state_d  = S_BWR;
      end

      S_BWR: begin
        jt_we    = 1'b1;
        jt_waddr = {lv_q, j_q};
        jt_wdata = jt_rdata;
        state_d  = S_BRD1;
        if (j_q == J_LAST) begin
          j_d = '0;
          if (lv_q == LV_LAST) begin
            anc_d   = '0;
            dist_d  = '0;
            ack_d   = 1'b1;
            state_d = S_OUT;
          end else begin
            lv_d = lv_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end

      // Query: fetch both depths
      S_QDB: begin
        dp_raddr = b_q;
        da_d     = dp_rdata;
        state_d  = S_QDW;
      end

      S_QDW: begin
        db_d = dp_rdata;
        lv_d = '0;
        if (da_q < dp_rdata) begin
          a_d    = b_q;
          b_d    = a_q;
          diff_d = dp_rdata - da_q;
        end else begin
          diff_d = da_q - dp_rdata;
        end
        state_d = S_LIFT;
      end

      // Lift the deeper node by the set bits of the depth gap
      S_LIFT: begin
        if (diff_q[0]) begin
          jt_raddr = {lv_q, a_q};
          state_d  = S_LIFTW;
        end else begin
          diff_d = diff_q >> 1;
          if (lift_end) begin
            state_d = S_CHK;
          end else begin
            lv_d = lv_q + 1'b1;
          end
        end
      end

      S_LIFTW: begin
        a_d    = jt_idx;
        diff_d = diff_q >> 1;
        if (lift_end) begin
          state_d = S_CHK;
        end else begin
          lv_d    = lv_q + 1'b1;
          state_d = S_LIFT;
        end
      end

      S_CHK: begin
        if (a_q == b_q) begin
          anc_d    = a_q;
          dp_raddr = a_q;
          state_d  = S_DCW;
        end else begin
          lv_d    = LV_LAST;
          state_d = S_CLA;
        end
      end

      // Climb both nodes while their ancestors differ
      S_CLA: begin
        jt_raddr = {lv_q, a_q};
        state_d  = S_CLB;
      end

      S_CLB: begin
        jt_raddr = {lv_q, b_q};
        ca_d     = jt_idx;
        state_d  = S_CLC;
      end

      S_CLC: begin
        if (ca_q != jt_idx) begin
          a_d = ca_q;
          b_d = jt_idx;
        end
        if (lv_q == '0) begin
          state_d = S_FIN;
        end else begin
          lv_d    = lv_dn;
          state_d = S_CLA;
        end
      end

      S_FIN: begin
        jt_raddr = {LVW'(0), a_q};
        state_d  = S_FINW;
      end

      S_FINW: begin
        anc_d    = jt_idx;
        dp_raddr = jt_idx;
        state_d  = S_DCW;
      end

      // Path length with saturation
      S_DCW: begin
        if (sum < twice) begin
          dist_d = '0;
        end else if (gap > {1'b0, DIST_MAX}) begin
          dist_d = DIST_MAX;
        end else begin
          dist_d = DIST_W'(gap);
        end
        ack_d   = 1'b0;
        state_d = S_OUT;
      end

      // Hand the result to the output register once it is free
      S_OUT: begin
        if (out_free) begin
          rsp_valid_d        = 1'b1;
          rsp_d.ancestor     = NODE_W'(anc_q);
          rsp_d.distance     = dist_q;
          rsp_d.is_build_ack = ack_q;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    raw_q    <= raw_d;
    quo_q    <= quo_d;
    dep_in_q <= dep_in_d;
    a_q      <= a_d;
    b_q      <= b_d;
    ca_q     <= ca_d;
    anc_q    <= anc_d;
    j_q      <= j_d;
    da_q     <= da_d;
    db_q     <= db_d;
    diff_q   <= diff_d;
    lv_q     <= lv_d;
    dist_q   <= dist_d;
    ack_q    <= ack_d;
    rsp_q    <= rsp_d;
  end

`ifndef SYNTHESIS
  // A taken request keeps the engine busy for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("engine took a request on consecutive cycles");

  // Build acknowledge carries zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.is_build_ack |->
      rsp_o.data.ancestor == '0 && rsp_o.data.distance == '0)
    else $error("build acknowledge with nonzero payload");

  // Jump table is written only by a load or by the build sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    jt_we |-> state_q == S_BWR || (state_q == S_RED2 && op_q == OP_LOAD))
    else $error("jump table written outside load or build");

  // A finished result reaches the output and frees the engine
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && out_free |=> rsp_o.valid && state_q == S_IDLE)
    else $error("finished result not presented");
`endif

endmodule

`default_nettype wire

/* hdl/tlca_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlca_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlca_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Register read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

/* tb/lca_answer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lca_answer_checker
// Watches the request and result channels of the LCA distance engine, keeps
// its own jump and depth tables, predicts every build acknowledge and query
// answer, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module lca_answer_checker
  import tlca_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 11
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_ready_i,
  input  req_t req_data_i,
  input  logic rsp_valid_i,
  input  logic rsp_ready_i,
  input  rsp_t rsp_data_i,
  output int   mismatch_cnt_o,
  output int   waiting_o
);

  logic [NODE_W-1:0]  hop_tbl   [LEVELS][MAX_NODES];
  logic [DEPTH_W-1:0] depth_tbl [MAX_NODES];
  rsp_t               answer_q  [$];
  rsp_t               want;
  int                 mismatch_cnt;

  // Start from zeroed tables; the stimulus never reads an unwritten entry
  initial begin
    foreach (hop_tbl[lv, j]) hop_tbl[lv][j] = '0;
    foreach (depth_tbl[j]) depth_tbl[j] = '0;
  end

  function automatic int wrap(input int v);
    return v % MAX_NODES;
  endfunction

  // Fill lifting levels 1 and up, each from the level below
  function automatic void fill_hops();
    for (int lv = 1; lv < LEVELS; lv++) begin
      for (int j = 0; j < MAX_NODES; j++) begin
        hop_tbl[lv][j] = hop_tbl[lv-1][wrap(int'(hop_tbl[lv-1][j]))];
      end
    end
  endfunction

  // Lift the deeper node to the other's depth, then climb both while apart
  function automatic rsp_t answer_query(input int first, input int second);
    int   a, b, tmp, gap, ca, cb, anc, path_len;
    rsp_t r;
    a = wrap(first);
    b = wrap(second);
    if (depth_tbl[a] < depth_tbl[b]) begin
      tmp = a;
      a   = b;
      b   = tmp;
    end
    gap = int'(depth_tbl[a]) - int'(depth_tbl[b]);
    for (int lv = 0; lv < LEVELS; lv++) begin
      if ((gap >> lv) & 1) a = wrap(int'(hop_tbl[lv][a]));
    end
    if (a == b) begin
      anc = a;
    end else begin
      for (int k = LEVELS - 1; k >= 0; k--) begin
        ca = wrap(int'(hop_tbl[k][a]));
        cb = wrap(int'(hop_tbl[k][b]));
        if (ca != cb) begin
          a = ca;
          b = cb;
        end
      end
      anc = wrap(int'(hop_tbl[0][a]));
    end
    // Clamp the path length; inconsistent depths can push it out of range
    path_len = int'(depth_tbl[wrap(first)]) + int'(depth_tbl[wrap(second)])
               - 2 * int'(depth_tbl[anc]);
    if (path_len < 0) path_len = 0;
    if (path_len > int'(DIST_MAX)) path_len = int'(DIST_MAX);
    r.ancestor     = NODE_W'(anc);
    r.distance     = DIST_W'(path_len);
    r.is_build_ack = 1'b0;
    return r;
  endfunction

  // Compare results first, since a request accepted on the same edge
  // cannot have produced them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (answer_q.size() == 0) begin
          $error("result with nothing expected: ancestor %0d distance %0d ack %0b",
                 rsp_data_i.ancestor, rsp_data_i.distance, rsp_data_i.is_build_ack);
          mismatch_cnt++;
        end else begin
          want = answer_q.pop_front();
          if (rsp_data_i.ancestor !== want.ancestor) begin
            $error("ancestor: expected %0d, actual %0d", want.ancestor,
                   rsp_data_i.ancestor);
            mismatch_cnt++;
          end
          if (rsp_data_i.distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance,
                   rsp_data_i.distance);
            mismatch_cnt++;
          end
          if (rsp_data_i.is_build_ack !== want.is_build_ack) begin
            $error("is_build_ack: expected %0b, actual %0b", want.is_build_ack,
                   rsp_data_i.is_build_ack);
            mismatch_cnt++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        case (req_data_i.opcode)
          OP_LOAD: begin
            hop_tbl[0][wrap(int'(req_data_i.node))] = req_data_i.parent;
            depth_tbl[wrap(int'(req_data_i.node))]  = req_data_i.node_depth;
          end
          OP_BUILD: begin
            fill_hops();
            answer_q.insert(answer_q.size(),
                            rsp_t'{ancestor: '0, distance: '0, is_build_ack: 1'b1});
          end
          OP_QUERY: begin
            answer_q.insert(answer_q.size(),
                            answer_query(int'(req_data_i.node),
                                         int'(req_data_i.other_node)));
          end
          default: begin
            // Drop the unused code: no result, no table change
          end
        endcase
      end
    end
    mismatch_cnt_o <= mismatch_cnt;
    waiting_o      <= answer_q.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the LCA distance engine with a full tree load, a directed set of
// queries and edge cases, then random leaf moves, stray entries, queries and
// rebuilds under three idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import tlca_pkg::*;

  localparam int NODE_COUNT   = 1024;
  localparam int LIFT_LEVELS  = 11;
  localparam int DEPTH_TOP    = (1 << DEPTH_W) - 1;
  localparam int ROOT         = 0;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int ROUNDS       = 25;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   tx_idle_pct = 29;
  int   rx_idle_pct = 61;
  int   cycle_cnt   = 0;
  int   mismatch_cnt;
  int   waiting;

  // Shadow of the tree as the stimulus intends it
  int tree_parent [NODE_COUNT];
  int tree_depth  [NODE_COUNT];
  int kid_cnt     [NODE_COUNT];

  tlca_stream_if #(.T(req_t)) req_if ();
  tlca_stream_if #(.T(rsp_t)) rsp_if ();

  tree_lca_distance_engine #(
    .MAX_NODES (NODE_COUNT),
    .LEVELS    (LIFT_LEVELS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  lca_answer_checker #(
    .MAX_NODES (NODE_COUNT),
    .LEVELS    (LIFT_LEVELS)
  ) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_if.valid),
    .req_ready_i    (req_if.ready),
    .req_data_i     (req_if.data),
    .rsp_valid_i    (rsp_if.valid),
    .rsp_ready_i    (rsp_if.ready),
    .rsp_data_i     (rsp_if.data),
    .mismatch_cnt_o (mismatch_cnt),
    .waiting_o      (waiting)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // End the run if it hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tree_lca_distance_engine verification failed");
      $finish;
    end
  end

  // Hold one request until accepted; leave valid high for a back-to-back one
  task automatic issue(input logic [OP_W-1:0] op, input int n, input int p,
                       input int d, input int m);
    req_t r;
    r.opcode     = op;
    r.node       = NODE_W'(n);
    r.parent     = NODE_W'(p);
    r.node_depth = DEPTH_W'(d);
    r.other_node = NODE_W'(m);
    if ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
  endtask

  function automatic int climb(input int v, input int steps);
    int n;
    n = v;
    repeat (steps) n = tree_parent[n];
    return n;
  endfunction

  task automatic random_block(input int rounds);
    int v, w, p, tmp, pick, tries;
    for (int k = 0; k < rounds; k++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // Query a random pair, a node with itself, or a node with an ancestor
        v = $urandom_range(NODE_COUNT - 1);
        case ($urandom_range(3))
          0:       w = v;
          1:       w = climb(v, $urandom_range(40));
          default: w = $urandom_range(NODE_COUNT - 1);
        endcase
        if ($urandom_range(1)) begin
          tmp = v;
          v   = w;
          w   = tmp;
        end
        issue(OP_QUERY, v, $urandom, $urandom, w);
      end else if (pick < 80) begin
        // Move a leaf under a new parent, keeping the shadow tree consistent
        v     = ROOT;
        tries = 0;
        while (v == ROOT && tries < 64) begin
          w = $urandom_range(NODE_COUNT - 1, 1);
          if (kid_cnt[w] == 0) v = w;
          tries++;
        end
        if (v != ROOT) begin
          p = $urandom_range(NODE_COUNT - 1);
          while (p == v || tree_depth[p] >= DEPTH_TOP) p = $urandom_range(NODE_COUNT - 1);
          kid_cnt[tree_parent[v]]--;
          kid_cnt[p]++;
          tree_parent[v] = p;
          tree_depth[v]  = tree_depth[p] + 1;
          issue(OP_LOAD, v, p, tree_depth[v], $urandom);
        end
      end else if (pick < 94) begin
        // Overwrite a node with a stray entry, ask about it, then restore it
        v = $urandom_range(NODE_COUNT - 1);
        issue(OP_LOAD, v, $urandom, $urandom, $urandom);
        issue(OP_QUERY, v, $urandom, $urandom, $urandom_range(NODE_COUNT - 1));
        issue(OP_QUERY, $urandom_range(NODE_COUNT - 1), $urandom, $urandom, v);
        issue(OP_LOAD, v, tree_parent[v], tree_depth[v], $urandom);
      end else begin
        issue(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int p, deep;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    rst_ni       <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Load a chain-heavy tree over every node so all table entries are written
    tree_parent[ROOT] = ROOT;
    tree_depth[ROOT]  = 0;
    issue(OP_LOAD, ROOT, ROOT, 0, $urandom);
    for (int j = 1; j < NODE_COUNT; j++) begin
      p = ($urandom_range(3) != 0) ? j - 1 : $urandom_range(j - 1);
      tree_parent[j] = p;
      tree_depth[j]  = tree_depth[p] + 1;
      kid_cnt[p]++;
      issue(OP_LOAD, j, p, tree_depth[j], $urandom);
    end
    issue(OP_BUILD, $urandom, $urandom, $urandom, $urandom);

    // Directed queries: root, deepest node, both orders, parent, midway
    deep = ROOT;
    foreach (tree_depth[j]) if (tree_depth[j] > tree_depth[deep]) deep = j;
    issue(OP_QUERY, ROOT, 0, 0, ROOT);
    issue(OP_QUERY, deep, 0, 0, ROOT);
    issue(OP_QUERY, ROOT, DEPTH_TOP, DEPTH_TOP, deep);
    issue(OP_QUERY, deep, 0, 0, deep);
    issue(OP_QUERY, NODE_COUNT - 1, 0, 0, deep);
    issue(OP_QUERY, deep, 0, 0, climb(deep, 1));
    issue(OP_QUERY, climb(deep, tree_depth[deep] / 2), 0, 0, deep);
    issue(OP_QUERY, 1, 0, 0, NODE_COUNT - 1);
    issue(OP_QUERY, NODE_COUNT / 2, 0, 0, NODE_COUNT / 2 + 1);

    // Unused code with every field set must leave the tables alone
    issue(OP_UNUSED, NODE_COUNT - 1, NODE_COUNT - 1, DEPTH_TOP, NODE_COUNT - 1);
    issue(OP_QUERY, deep, 0, 0, NODE_COUNT - 1);

    // Root at the maximum depth: the path length saturates at zero
    issue(OP_LOAD, ROOT, ROOT, DEPTH_TOP, 0);
    issue(OP_QUERY, 1, 0, 0, ROOT);
    issue(OP_QUERY, deep, 0, 0, NODE_COUNT - 1);
    issue(OP_LOAD, ROOT, ROOT, 0, 0);

    // Last node as a self-parented second root at the maximum depth
    issue(OP_LOAD, NODE_COUNT - 1, NODE_COUNT - 1, DEPTH_TOP, NODE_COUNT - 1);
    issue(OP_QUERY, NODE_COUNT - 1, 0, 0, ROOT);
    issue(OP_QUERY, deep, 0, 0, NODE_COUNT - 1);
    issue(OP_LOAD, NODE_COUNT - 1, tree_parent[NODE_COUNT - 1],
          tree_depth[NODE_COUNT - 1], 0);

    // Random phases: receiver-heavy idling, sender-heavy idling, none
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 61 : 0;
      rx_idle_pct <= (phase == 0) ? 61 : (phase == 1) ? 29 : 0;
      for (int blk = 0; blk < 3; blk++) begin
        random_block(ROUNDS);
        if (blk < 2) issue(OP_BUILD, $urandom, $urandom, $urandom, $urandom);
      end
    end

    // Drain outstanding results, then give the engine time to finish
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tree_lca_distance_engine verification clean");
    end else begin
      $display("tree_lca_distance_engine verification failed");
    end
    $finish;
  end

endmodule
